// ===== rtl/oqe_pkg.sv =====
// package for the ordered queue engine: request, status and cell command codes
// no dependencies; imported by the interfaces, the cells, the top level and the checker
package oqe_pkg;

  localparam int unsigned OQE_DEPTH       = 16;
  localparam int unsigned OQE_VALUE_WIDTH = 16;

  // request codes; codes above peek behave as peek
  typedef enum logic [2:0] {
    REQ_APPEND   = 3'd0,
    REQ_INSERT   = 3'd1,
    REQ_POP      = 3'd2,
    REQ_CONTAINS = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_PEEK     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what the cell row does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  // broadcast control to every cell
  typedef struct packed {
    cmd_e cmd;
    logic descending;
  } cell_ctl_t;

endpackage

// ===== rtl/oqe_if.sv =====
// handshake channels of the ordered queue engine: request, response, configuration
// depends on oqe_pkg
interface oqe_req_if
  import oqe_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = OQE_VALUE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             req_type;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface oqe_rsp_if
  import oqe_pkg::*;
#(
  parameter int unsigned DEPTH       = OQE_DEPTH,
  parameter int unsigned VALUE_WIDTH = OQE_VALUE_WIDTH
);
  localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [VALUE_WIDTH-1:0] popped_value;
  logic                   found;
  logic [VALUE_WIDTH-1:0] head_value;
  logic                   is_empty;
  logic [CNT_WIDTH-1:0]   entry_total;

  modport source (output valid, status, popped_value, found, head_value, is_empty,
                  entry_total, input ready);
  modport sink   (input valid, status, popped_value, found, head_value, is_empty,
                  entry_total, output ready);
endinterface

interface oqe_cfg_if;
  logic valid;
  logic ready;
  logic order_descending;

  modport source (output valid, order_descending, input ready);
  modport sink   (input valid, order_descending, output ready);
endinterface

// ===== rtl/ordered_queue_engine_core.sv =====
// top level of the ordered queue engine: fill counter, request decode, response register
// depends on oqe_pkg, oqe_if (channels) and oqe_cell (the row of slots)
//
// usage
// - req carries one request transaction (req_type, value); rsp returns exactly one
//   response transaction per request, in order; cfg writes order_descending
//   (0 ascending, 1 descending) for ordered insert, and is always ready
// - slot 0 of the cell row is the head; every cell compares its entry with the
//   request value in parallel and a first-hit flag ripples down the row, so each
//   cell knows whether to keep, load the new value or take its neighbor's entry
// - latency: the response is valid the cycle after the request is accepted
// - throughput: one request per cycle while the response is not stalled; the cycle
//   time is set by the first-hit ripple through DEPTH cells
// - a stalled response holds the request channel: req.ready is high only when the
//   response register is empty or being taken in the same cycle
// - head_value, is_empty and entry_total are read from the live queue, which does
//   not move while a response waits
// - reset empties the queue and clears order_descending; slot contents are not
//   reset, entries past the fill count are never shown
module ordered_queue_engine_core
  import oqe_pkg::*;
#(
  parameter int unsigned DEPTH       = OQE_DEPTH,
  parameter int unsigned VALUE_WIDTH = OQE_VALUE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  oqe_req_if.sink   req,
  oqe_rsp_if.source rsp,
  oqe_cfg_if.sink   cfg
);

  localparam int unsigned          CNT_WIDTH = $clog2(DEPTH + 1);
  localparam logic [CNT_WIDTH-1:0] DEPTH_C   = CNT_WIDTH'(DEPTH);
  localparam logic [CNT_WIDTH-1:0] ONE_C     = CNT_WIDTH'(1);

  // queue state
  logic [CNT_WIDTH-1:0] count_q, count_d;
  logic                 order_q;

  // response register
  logic                   rsp_valid_q;
  status_e                status_q, status_d;
  logic [VALUE_WIDTH-1:0] popped_q, popped_d;
  logic                   found_q, found_d;

  // cell row links
  logic [VALUE_WIDTH-1:0] slot   [DEPTH];
  logic [DEPTH-1:0]       match;
  logic [DEPTH-1:0]       seen;
  cell_ctl_t              ctl;

  logic accept, full, empty;

  assign accept = req.valid && req.ready;
  assign full   = count_q == DEPTH_C;
  assign empty  = count_q == '0;

  // request decode: drives the row command, the next count and the response fields
  always_comb begin
    ctl.cmd        = CMD_HOLD;
    ctl.descending = order_q;
    count_d        = count_q;
    status_d       = ST_OK;
    popped_d       = '0;
    found_d        = 1'b0;
    if (accept) begin
      unique case (req.req_type)
        REQ_APPEND, REQ_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl.cmd = (req.req_type == REQ_APPEND) ? CMD_APPEND : CMD_INSERT;
            count_d = count_q + ONE_C;
          end
        end
        REQ_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctl.cmd  = CMD_POP;
            count_d  = count_q - ONE_C;
            popped_d = slot[0];
          end
        end
        REQ_CONTAINS: found_d = |match;
        REQ_CLEAR:    count_d = '0;
        default:      count_d = count_q;  // peek and unused codes only report
      endcase
    end
  end

  // the row of slots, head at index 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v, right_v;
    logic                   prev_match, seen_in;

    if (g == 0) begin : g_head
      assign left_v     = '0;
      assign prev_match = 1'b0;
      assign seen_in    = 1'b0;
    end else begin : g_body
      assign left_v     = slot[g-1];
      assign prev_match = match[g-1];
      assign seen_in    = seen[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_v = slot[g];
    end else begin : g_inner
      assign right_v = slot[g+1];
    end

    oqe_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .value_i     (req.value),
      .left_i      (left_v),
      .right_i     (right_v),
      .prev_match_i(prev_match),
      .seen_i      (seen_in),
      .slot_o      (slot[g]),
      .match_o     (match[g]),
      .seen_o      (seen[g])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      order_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg.valid) begin
        order_q <= cfg.order_descending;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
      found_q  <= found_d;
    end
  end

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid        = rsp_valid_q;
  assign rsp.status       = status_q;
  assign rsp.popped_value = popped_q;
  assign rsp.found        = found_q;
  assign rsp.head_value   = empty ? '0 : slot[0];
  assign rsp.is_empty     = empty;
  assign rsp.entry_total  = count_q;

endmodule

// ===== rtl/oqe_cell.sv =====
// one slot of the queue: compare against the request value and shift with its neighbors
// depends on oqe_pkg
module oqe_cell
  import oqe_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = OQE_VALUE_WIDTH,
  parameter int unsigned CNT_WIDTH   = 5,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk_i,
  input  cell_ctl_t              ctl_i,
  input  logic [CNT_WIDTH-1:0]   count_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic                   prev_match_i,
  input  logic                   seen_i,
  output logic [VALUE_WIDTH-1:0] slot_o,
  output logic                   match_o,
  output logic                   seen_o
);

  localparam logic [CNT_WIDTH-1:0] IDX_C = CNT_WIDTH'(IDX);

  logic [VALUE_WIDTH-1:0] slot_q, slot_d;
  logic                   occupied, at_tail, beyond, place;

  assign occupied = IDX_C < count_i;
  assign at_tail  = IDX_C == count_i;
  assign beyond   = ctl_i.descending ? (slot_q < value_i) : (slot_q > value_i);
  assign match_o  = occupied && (slot_q == value_i);

  // this cell is a candidate position for the new value
  always_comb begin
    case (ctl_i.cmd)
      CMD_APPEND: place = at_tail;
      CMD_INSERT: place = (occupied && beyond) || prev_match_i || at_tail;
      default:    place = 1'b0;
    endcase
  end

  assign seen_o = seen_i | place;

  always_comb begin
    slot_d = slot_q;
    case (ctl_i.cmd)
      CMD_APPEND, CMD_INSERT: begin
        if (seen_i) begin
          slot_d = left_i;
        end else if (place) begin
          slot_d = value_i;
        end
      end
      CMD_POP: slot_d = right_i;
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== rtl/oqe_checker.sv =====
// port-level checks for the ordered queue engine, bound to the top level
// depends on oqe_pkg and ordered_queue_engine_core
module oqe_checker
  import oqe_pkg::*;
#(
  parameter int unsigned DEPTH       = OQE_DEPTH,
  parameter int unsigned VALUE_WIDTH = OQE_VALUE_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic [2:0]                     req_type_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [1:0]                     rsp_status_i,
  input logic [VALUE_WIDTH-1:0]         rsp_popped_i,
  input logic                           rsp_found_i,
  input logic                           rsp_empty_i,
  input logic [$clog2(DEPTH + 1)-1:0]   rsp_total_i
);

  localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

  // empty flag agrees with the entry count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_empty_i == (rsp_total_i == '0)))
    else $error("is_empty disagrees with entry_total");

  // never more entries than slots
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_total_i <= CNT_WIDTH'(DEPTH)))
    else $error("entry_total exceeds depth");

  // a clear answers next cycle with an empty queue
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_type_i == REQ_CLEAR))
      |=> (rsp_valid_i && rsp_empty_i))
    else $error("clear did not leave the queue empty");

  // a pop on empty reports nothing popped and an empty queue; found needs entries
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == ST_EMPTY))
      |-> (rsp_popped_i == '0 && rsp_empty_i && !rsp_found_i))
    else $error("empty pop reported data");

  // a stalled response stays up
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped while stalled");

endmodule

bind ordered_queue_engine_core oqe_checker #(
  .DEPTH      (DEPTH),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_oqe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .req_type_i  (req.req_type),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_status_i(rsp.status),
  .rsp_popped_i(rsp.popped_value),
  .rsp_found_i (rsp.found),
  .rsp_empty_i (rsp.is_empty),
  .rsp_total_i (rsp.entry_total)
);

// ===== dv/oqe_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the ordered queue engine: queue predictor and in-order response checker
// depends on oqe_pkg for the request and status codes and the queue dimensions
package oqe_scoreboard_pkg;
  import oqe_pkg::*;

  localparam int unsigned CNT_W = $clog2(OQE_DEPTH + 1);

  // spare request codes, the block treats them as peek
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef logic [OQE_VALUE_WIDTH-1:0] word_t;

  typedef struct packed {
    status_e          status;
    word_t            popped;
    logic             found;
    word_t            head;
    logic             empty;
    logic [CNT_W-1:0] total;
  } queue_rsp_t;

  class queue_scoreboard;
    word_t       entries[OQE_DEPTH];
    int unsigned used;
    bit          descending;
    queue_rsp_t  awaited[$];
    int unsigned errors, requests, responses, drops, empty_pops, hits;

    function new();
      used       = 0;
      descending = 1'b0;
      errors     = 0;
      requests   = 0;
      responses  = 0;
      drops      = 0;
      empty_pops = 0;
      hits       = 0;
    endfunction

    function void set_order(bit desc);
      descending = desc;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // a lies past b in the current sort order
    function bit past(word_t a, word_t b);
      return descending ? (a < b) : (a > b);
    endfunction

    function int unsigned sorted_slot(word_t v);
      if (used == 0 || past(entries[0], v)) return 0;
      for (int unsigned i = 0; i < used; i++) begin
        if (entries[i] == v) return i + 1;
        if (i + 1 < used && past(entries[i + 1], v)) return i + 1;
      end
      return used;
    endfunction

    // apply one accepted request to the queue image and queue up its response
    function void note_request(logic [2:0] code, word_t v);
      queue_rsp_t  r;
      int unsigned at;
      r = '0;
      r.status = ST_OK;
      requests++;
      case (code)
        REQ_APPEND, REQ_INSERT: begin
          if (used >= OQE_DEPTH) begin
            r.status = ST_FULL;
            drops++;
          end else begin
            at = (code == REQ_APPEND) ? used : sorted_slot(v);
            for (int unsigned i = used; i > at; i--) entries[i] = entries[i - 1];
            entries[at] = v;
            used++;
          end
        end
        REQ_POP: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
            empty_pops++;
          end else begin
            r.popped = entries[0];
            for (int unsigned i = 1; i < used; i++) entries[i - 1] = entries[i];
            used--;
          end
        end
        REQ_CONTAINS: begin
          for (int unsigned i = 0; i < used; i++)
            if (entries[i] == v) r.found = 1'b1;
          if (r.found) hits++;
        end
        REQ_CLEAR: used = 0;
        default: ;
      endcase
      r.head  = (used != 0) ? entries[0] : '0;
      r.empty = (used == 0);
      r.total = used[CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_response(queue_rsp_t got);
      queue_rsp_t want;
      responses++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected response, expected none actual status %0h head %0h",
                   $time, got.status, got.head);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("popped_value", want.popped, got.popped);
      compare_field("found", want.found, got.found);
      compare_field("head_value", want.head, got.head);
      compare_field("is_empty", want.empty, got.empty);
      compare_field("entry_total", want.total, got.total);
    endfunction
  endclass

endpackage

// ===== dv/ordered_queue_engine_core_test.sv =====
`timescale 1ns / 1ps
// testbench top for ordered_queue_engine_core: drives request and config channels,
// stalls the response channel, and checks every response against oqe_scoreboard_pkg
module ordered_queue_engine_core_test;
  import oqe_pkg::*;
  import oqe_scoreboard_pkg::*;

  // generous bound for roughly two thousand requests with their stalls and idle gaps
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 380;

  typedef struct packed {
    logic [2:0] code;
    word_t      value;
  } queue_req_t;

  // directed opening: empty-queue corner cases, spare codes, fill to the brim
  // with both extreme values and duplicates, then drops on a full queue
  localparam queue_req_t DIRECTED [27] = '{
    '{REQ_POP, 16'h0000},      '{REQ_PEEK, 16'h1234},     '{REQ_SPARE_LO, 16'hffff},
    '{REQ_SPARE_HI, 16'h0000}, '{REQ_CONTAINS, 16'h0000}, '{REQ_APPEND, 16'hffff},
    '{REQ_APPEND, 16'h0000},   '{REQ_APPEND, 16'h8000},   '{REQ_INSERT, 16'h4000},
    '{REQ_INSERT, 16'h0001},   '{REQ_INSERT, 16'h0000},   '{REQ_INSERT, 16'hffff},
    '{REQ_INSERT, 16'h7fff},   '{REQ_INSERT, 16'h8000},   '{REQ_INSERT, 16'h0005},
    '{REQ_INSERT, 16'h0005},   '{REQ_INSERT, 16'haaaa},   '{REQ_INSERT, 16'h5555},
    '{REQ_INSERT, 16'hfffe},   '{REQ_INSERT, 16'h0001},   '{REQ_INSERT, 16'h0002},
    '{REQ_APPEND, 16'h0003},   '{REQ_INSERT, 16'h0003},   '{REQ_CONTAINS, 16'haaaa},
    '{REQ_CONTAINS, 16'h1234}, '{REQ_POP, 16'h0000},      '{REQ_CLEAR, 16'h0000}
  };

  // request mix per regime as cumulative percentages:
  // append, insert, pop, contains, clear, peek, spare code for the rest
  localparam int unsigned MIX [3][6] = '{
    '{30, 65, 78, 90, 92, 97},  // filling
    '{10, 25, 65, 82, 86, 95},  // draining
    '{20, 45, 70, 88, 90, 96}   // balanced
  };
  localparam logic [2:0] CODE_TAB [7] = '{
    REQ_APPEND, REQ_INSERT, REQ_POP, REQ_CONTAINS, REQ_CLEAR, REQ_PEEK, REQ_SPARE_LO
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_en;
  int unsigned cycles;
  int unsigned stall_left;

  queue_scoreboard sb;

  oqe_req_if req_ch ();
  oqe_rsp_if rsp_ch ();
  oqe_cfg_if cfg_ch ();

  ordered_queue_engine_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog, also the only way out if the block hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // monitor: everything is sampled at the rising edge, inputs only move at the falling one
  always @(posedge clk_i) begin
    queue_rsp_t got;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_order(cfg_ch.order_descending);
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.req_type, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = status_e'(rsp_ch.status);
        got.popped = rsp_ch.popped_value;
        got.found  = rsp_ch.found;
        got.head   = rsp_ch.head_value;
        got.empty  = rsp_ch.is_empty;
        got.total  = rsp_ch.entry_total;
        sb.check_response(got);
      end
    end
  end

  // response back-pressure: random stall bursts of random length while idling is on
  initial begin
    rsp_ch.ready = 1'b1;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // one request transaction; entered and left at a falling edge, valid stays high
  // across back-to-back transactions and only drops for an idle burst
  task automatic send_request(input logic [2:0] code, input word_t v);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= code;
    req_ch.value    <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // wait until every response is in, then let the response register settle
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // order register write, only issued with the block idle
  task automatic write_order(input bit desc);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.order_descending <= desc;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // random phase: regimes that fill, drain or balance the queue so that full drops,
  // empty pops and long shifts all come up; values lean on a small pool for duplicates
  task automatic run_phase(input bit desc, input int unsigned count);
    int unsigned regime, left, roll, k, sel;
    logic [2:0]  code;
    word_t       v;
    left   = 0;
    regime = 0;
    write_order(desc);
    for (int unsigned n = 0; n < count; n++) begin
      if (left == 0) begin
        regime = $urandom_range(0, 2);
        left   = $urandom_range(10, 40);
      end
      left--;
      roll = $urandom_range(0, 99);
      k    = 0;
      while (k < 6 && roll >= MIX[regime][k]) k++;
      code = CODE_TAB[k];
      if (k == 6 && $urandom_range(0, 1) == 1) code = REQ_SPARE_HI;
      sel = $urandom_range(0, 9);
      if (sel < 5) v = word_t'($urandom_range(0, 7));
      else if (sel == 5) v = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      else if (sel == 6) v = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      else v = word_t'($urandom_range(0, 16'hffff));
      send_request(code, v);
    end
    req_ch.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    sb                      = new();
    cycles                  = 0;
    idle_en                 = 1'b1;
    rst_ni                  = 1'b0;
    req_ch.valid            = 1'b0;
    req_ch.req_type         = REQ_PEEK;
    req_ch.value            = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.order_descending = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part in ascending order
    write_order(1'b0);
    foreach (DIRECTED[i]) send_request(DIRECTED[i].code, DIRECTED[i].value);
    req_ch.valid <= 1'b0;
    wait_drained();

    // random part, order flipping between phases, no idling in the last one
    run_phase(1'b1, PHASE_ITEMS);
    run_phase(1'b0, PHASE_ITEMS);
    run_phase(1'b1, PHASE_ITEMS);
    run_phase(1'b0, PHASE_ITEMS);
    idle_en = 1'b0;
    run_phase(1'b1, PHASE_ITEMS);
    repeat (4) @(negedge clk_i);

    $display("covered %0d requests and %0d responses in both sort orders", sb.requests,
             sb.responses);
    $display("full drops %0d, pops on empty %0d, contains hits %0d", sb.drops,
             sb.empty_pops, sb.hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== ordered_queue_engine_core.f =====
rtl/oqe_pkg.sv
rtl/oqe_if.sv
rtl/oqe_cell.sv
rtl/ordered_queue_engine_core.sv
rtl/oqe_checker.sv
dv/oqe_scoreboard_pkg.sv
dv/ordered_queue_engine_core_test.sv
